// ===== design/wels_pkg.sv =====
// Shared types, constants and helpers for the leapfrog wave-equation stencil.
// No dependencies; every other design file except wels_ram imports this package.
`default_nettype none

package wels_pkg;

    // Grid and number format
    localparam int MAX_POINTS = 64;
    localparam int FRAC_BITS  = 16;
    localparam int MIN_POINTS = 3;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int VAL_W      = 32;
    localparam int NP_W       = 7;
    localparam int COEF_W     = FRAC_BITS + 1;

    // Datapath widths
    localparam int LAP_W  = VAL_W + 3;            // r - 2c + l
    localparam int BASE_W = VAL_W + 2;            // 2c - older
    localparam int P1_W   = LAP_W + COEF_W + 1;   // coefficient times laplacian
    localparam int P2_W   = VAL_W + COEF_W + 1;   // coefficient times curvature
    localparam int ACC_W  = P1_W + 1;
    localparam int SH_W   = ACC_W - FRAC_BITS;
    localparam int SUM_W  = SH_W + 1;

    localparam logic [COEF_W-1:0] COEF_MAX   = COEF_W'(1) << FRAC_BITS;
    localparam logic [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);

    // Configuration port
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 4;

    localparam logic [NP_W-1:0]   NUM_POINTS_RST = NP_W'(11);
    localparam logic [COEF_W-1:0] COURANT_RST    = COEF_W'(65536);
    localparam logic [COEF_W-1:0] TAU_RST        = COEF_W'(6554);
    localparam logic [COEF_W-1:0] HALF_A2T2_RST  = COEF_W'(328);

    typedef enum logic [1:0] {
        REG_NUM_POINTS = 2'd0,
        REG_COURANT    = 2'd1,
        REG_TAU        = 2'd2,
        REG_HALF_A2T2  = 2'd3
    } reg_idx_t;

    // Input item kinds
    localparam logic KIND_INIT    = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    // Output queue
    localparam int FIFO_DEPTH = 8;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FPTR_W + 1;

    // Per-item control carried down the pipe
    typedef struct packed {
        logic             kind;
        logic             last;
        logic             bank;   // 1: bank b holds the newest layer
        logic [IDX_W-1:0] idx;
    } ctl_t;

    // One result beat
    typedef struct packed {
        logic [IDX_W-1:0] point_index;
        logic [VAL_W-1:0] new_value;
        logic             last_in_layer;
        logic             saturated;
    } res_t;

    // Coefficients above 1.0 act as 1.0
    function automatic logic [COEF_W-1:0] coef_clamp(input logic [COEF_W-1:0] c);
        coef_clamp = (c > COEF_MAX) ? COEF_MAX : c;
    endfunction

endpackage

`default_nettype wire

// ===== design/wels_point_if.sv =====
// Input channel of the stencil: valid/ready plus one grid point's fields.
// Depends on wels_pkg for field widths.
`default_nettype none

interface wels_point_if import wels_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic signed [VAL_W-1:0] init_value;
    logic signed [VAL_W-1:0] init_velocity;
    logic signed [VAL_W-1:0] init_curvature;
    logic signed [VAL_W-1:0] boundary_value;

    modport source (
        output valid, kind, init_value, init_velocity, init_curvature, boundary_value,
        input  ready
    );

    modport sink (
        input  valid, kind, init_value, init_velocity, init_curvature, boundary_value,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/wels_result_if.sv =====
// Output channel of the stencil: valid/ready plus one result point.
// Depends on wels_pkg for field widths.
`default_nettype none

interface wels_result_if import wels_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        point_index;
    logic signed [VAL_W-1:0] new_value;
    logic                    last_in_layer;
    logic                    saturated;

    modport source (
        output valid, point_index, new_value, last_in_layer, saturated,
        input  ready
    );

    modport sink (
        input  valid, point_index, new_value, last_in_layer, saturated,
        output ready
    );

endinterface

`default_nettype wire

// ===== design/wave_equation_leapfrog_stencil.sv =====
// Top level of the explicit leapfrog stencil for the 1D wave equation.
// Depends on wels_pkg, wels_point_if, wels_result_if and wels_ram.
//
// Usage
//   point  : input beats, one grid point each, in index order. kind = init loads
//            the initial value, velocity and curvature of a point; kind = advance
//            produces that point in the next time layer (boundary_value is used
//            at the first and last index).
//   result : one beat per input beat, in order: index, new value, last-point
//            flag and saturation flag.
//   APB    : four registers (point count, Courant coefficient, tau, a^2 tau^2 / 2)
//            at byte offsets 0, 4, 8, 12. Write only while the block is idle.
// Timing
//   One beat is taken every cycle while point.ready is high. The pipe is input
//   register, layer-store read, multiply, then round/saturate with the store
//   write-back. The store write of one point lands on the same edge as the read
//   two points later, so the stores forward same-address writes.
// Stall
//   Results queue in an eight-deep output buffer. point.ready drops only when
//   eight beats are accepted but not yet taken by the receiver.
// Reset
//   Registers return to their defaults, the index counter, bank select and left
//   neighbor clear, and the pipe empties. The layer stores are not cleared: a
//   layer of init beats must be loaded before the first advance beat.
`default_nettype none

module wave_equation_leapfrog_stencil import wels_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    wels_point_if.sink            point,
    wels_result_if.source         result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NP_W-1:0]   num_points_reg;
    logic [COEF_W-1:0] courant_reg;
    logic [COEF_W-1:0] tau_reg;
    logic [COEF_W-1:0] half_a2t2_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        unique case (cfg_idx)
            REG_NUM_POINTS: prdata = APB_DATA_W'(num_points_reg);
            REG_COURANT:    prdata = APB_DATA_W'(courant_reg);
            REG_TAU:        prdata = APB_DATA_W'(tau_reg);
            REG_HALF_A2T2:  prdata = APB_DATA_W'(half_a2t2_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // Index and bank control, decided at the accepting edge
    // ------------------------------------------------------------------
    logic             accept;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic             bank_reg;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] cur_idx;
    logic             cur_last;

    always_comb
    begin
        int np_i;
        np_i = int'(num_points_reg);
        if (np_i < MIN_POINTS)
        begin
            np_i = MIN_POINTS;
        end
        else if (np_i > MAX_POINTS)
        begin
            np_i = MAX_POINTS;
        end
        last_idx = IDX_W'(np_i - 1);
        // counter may sit past the end if the point count shrank
        cur_idx  = (cnt_reg > last_idx) ? last_idx : cnt_reg;
        cur_last = (cur_idx == last_idx);
        cnt_next = cur_last ? '0 : cur_idx + IDX_W'(1);
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    logic                    s1_vld_reg, s2_vld_reg, s3_vld_reg;
    ctl_t                    s1_ctl_reg, s2_ctl_reg, s3_ctl_reg;
    logic signed [VAL_W-1:0] s1_val_reg, s1_vel_reg, s1_curv_reg, s1_bnd_reg;
    logic signed [VAL_W-1:0] s2_val_reg, s2_vel_reg, s2_curv_reg, s2_bnd_reg;
    logic signed [VAL_W-1:0] s3_val_reg;
    logic signed [P1_W-1:0]  s3_p1_reg;
    logic signed [P2_W-1:0]  s3_p2_reg;
    logic signed [BASE_W-1:0] s3_base_reg;
    logic signed [VAL_W-1:0] lno_reg;

    // ------------------------------------------------------------------
    // Layer stores: two copies per bank give the centre and right reads
    // ------------------------------------------------------------------
    logic [IDX_W-1:0] rd_idx_c, rd_idx_r;
    logic [VAL_W-1:0] a0_rd, a1_rd, b0_rd, b1_rd;
    logic             a_we, b_we;
    logic [VAL_W-1:0] a_wd, b_wd;

    assign rd_idx_c = s1_ctl_reg.idx;
    assign rd_idx_r = s1_ctl_reg.idx + IDX_W'(1);

    wels_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_ram_a0 (
        .clk(clk), .we(a_we), .waddr(s3_ctl_reg.idx), .wdata(a_wd),
        .raddr(rd_idx_c), .rdata(a0_rd)
    );
    wels_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_ram_a1 (
        .clk(clk), .we(a_we), .waddr(s3_ctl_reg.idx), .wdata(a_wd),
        .raddr(rd_idx_r), .rdata(a1_rd)
    );
    wels_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_ram_b0 (
        .clk(clk), .we(b_we), .waddr(s3_ctl_reg.idx), .wdata(b_wd),
        .raddr(rd_idx_c), .rdata(b0_rd)
    );
    wels_ram #(.WIDTH(VAL_W), .DEPTH(MAX_POINTS)) u_ram_b1 (
        .clk(clk), .we(b_we), .waddr(s3_ctl_reg.idx), .wdata(b_wd),
        .raddr(rd_idx_r), .rdata(b1_rd)
    );

    // ------------------------------------------------------------------
    // Stage 2: select operands and multiply
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0]  newest_c, newest_r, older_c;
    logic                     interior;
    logic signed [COEF_W:0]   mul_coef;
    logic signed [LAP_W-1:0]  mul_opnd;
    logic signed [P1_W-1:0]   p1_next;
    logic signed [P2_W-1:0]   p2_next;
    logic signed [BASE_W-1:0] base_next;

    always_comb
    begin
        logic signed [LAP_W-1:0]  lap;
        logic signed [BASE_W-1:0] base_adv;
        logic signed [COEF_W:0]   half_c;

        newest_c = $signed(s2_ctl_reg.bank ? b0_rd : a0_rd);
        newest_r = $signed(s2_ctl_reg.bank ? b1_rd : a1_rd);
        older_c  = $signed(s2_ctl_reg.bank ? a0_rd : b0_rd);

        interior = (s2_ctl_reg.kind == KIND_ADVANCE) && (s2_ctl_reg.idx != '0)
                   && !s2_ctl_reg.last;

        lap      = LAP_W'(newest_r) - (LAP_W'(newest_c) <<< 1) + LAP_W'(lno_reg);
        base_adv = (BASE_W'(newest_c) <<< 1) - BASE_W'(older_c);
        half_c   = $signed({1'b0, coef_clamp(half_a2t2_reg)});

        if (s2_ctl_reg.kind == KIND_INIT)
        begin
            mul_coef  = $signed({1'b0, coef_clamp(tau_reg)});
            mul_opnd  = LAP_W'(s2_vel_reg);
            p2_next   = half_c * s2_curv_reg;
            base_next = BASE_W'(s2_val_reg);
        end
        else if (interior)
        begin
            mul_coef  = $signed({1'b0, coef_clamp(courant_reg)});
            mul_opnd  = lap;
            p2_next   = '0;
            base_next = base_adv;
        end
        else
        begin
            // boundary point: the result is the boundary value unchanged
            mul_coef  = '0;
            mul_opnd  = '0;
            p2_next   = '0;
            base_next = BASE_W'(s2_bnd_reg);
        end
        p1_next = mul_coef * mul_opnd;
    end

    // ------------------------------------------------------------------
    // Stage 3: round, add base, saturate, write back
    // ------------------------------------------------------------------
    logic signed [VAL_W-1:0] res_value;
    logic                    res_sat;
    logic [VAL_W-1:0]        older_wd;

    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic signed [SH_W-1:0]  sh;
        logic signed [SUM_W-1:0] sum;
        logic [SUM_W-VAL_W:0]    hi;

        acc = ACC_W'(s3_p1_reg) + ACC_W'(s3_p2_reg) + $signed(ROUND_HALF);
        sh  = $signed(acc[ACC_W-1:FRAC_BITS]);
        sum = SUM_W'(s3_base_reg) + SUM_W'(sh);
        hi  = sum[SUM_W-1:VAL_W-1];
        res_sat = !((&hi) || !(|hi));
        if (res_sat)
        begin
            res_value = sum[SUM_W-1] ? $signed({1'b1, {(VAL_W-1){1'b0}}})
                                     : $signed({1'b0, {(VAL_W-1){1'b1}}});
        end
        else
        begin
            res_value = sum[VAL_W-1:0];
        end
    end

    // older layer takes the init value or the new point; newest takes init results
    assign older_wd = (s3_ctl_reg.kind == KIND_INIT) ? s3_val_reg : res_value;
    assign a_we = s3_vld_reg && (s3_ctl_reg.bank || (s3_ctl_reg.kind == KIND_INIT));
    assign b_we = s3_vld_reg && (!s3_ctl_reg.bank || (s3_ctl_reg.kind == KIND_INIT));
    assign a_wd = s3_ctl_reg.bank ? older_wd : res_value;
    assign b_wd = s3_ctl_reg.bank ? res_value : older_wd;

    // ------------------------------------------------------------------
    // Output queue and outstanding count
    // ------------------------------------------------------------------
    res_t             fifo_mem_reg [FIFO_DEPTH];
    logic [CNT_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] out_cnt_reg;
    logic             out_fire;
    res_t             res_head;

    assign point.ready  = (out_cnt_reg != CNT_W'(FIFO_DEPTH));
    assign accept       = point.valid && point.ready;
    assign result.valid = (wr_ptr_reg != rd_ptr_reg);
    assign out_fire     = result.valid && result.ready;

    assign res_head             = fifo_mem_reg[rd_ptr_reg[FPTR_W-1:0]];
    assign result.point_index   = res_head.point_index;
    assign result.new_value     = $signed(res_head.new_value);
    assign result.last_in_layer = res_head.last_in_layer;
    assign result.saturated     = res_head.saturated;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NUM_POINTS_RST;
            courant_reg    <= COURANT_RST;
            tau_reg        <= TAU_RST;
            half_a2t2_reg  <= HALF_A2T2_RST;
            cnt_reg        <= '0;
            bank_reg       <= 1'b0;
            lno_reg        <= '0;
            s1_vld_reg     <= 1'b0;
            s2_vld_reg     <= 1'b0;
            s3_vld_reg     <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_NUM_POINTS: num_points_reg <= pwdata[NP_W-1:0];
                    REG_COURANT:    courant_reg    <= pwdata[COEF_W-1:0];
                    REG_TAU:        tau_reg        <= pwdata[COEF_W-1:0];
                    REG_HALF_A2T2:  half_a2t2_reg  <= pwdata[COEF_W-1:0];
                endcase
            end

            // advance the index; swap banks only at the end of an advance layer
            if (accept)
            begin
                cnt_reg <= cnt_next;
                if ((point.kind == KIND_ADVANCE) && cur_last)
                begin
                    bank_reg <= !bank_reg;
                end
            end

            // left neighbor follows the newest-layer value of the point in stage 2, or its init value for an init beat
            if (s2_vld_reg)
            begin
                lno_reg <= (s2_ctl_reg.kind == KIND_INIT) ? s2_val_reg : newest_c;
            end

            s1_vld_reg <= accept;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;

            if (s3_vld_reg)
            begin
                wr_ptr_reg <= wr_ptr_reg + CNT_W'(1);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + CNT_W'(1);
            end
            if (accept && !out_fire)
            begin
                out_cnt_reg <= out_cnt_reg + CNT_W'(1);
            end
            else if (!accept && out_fire)
            begin
                out_cnt_reg <= out_cnt_reg - CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg.kind <= point.kind;
            s1_ctl_reg.last <= cur_last;
            s1_ctl_reg.bank <= bank_reg;
            s1_ctl_reg.idx  <= cur_idx;
            s1_val_reg      <= point.init_value;
            s1_vel_reg      <= point.init_velocity;
            s1_curv_reg     <= point.init_curvature;
            s1_bnd_reg      <= point.boundary_value;
        end

        s2_ctl_reg  <= s1_ctl_reg;
        s2_val_reg  <= s1_val_reg;
        s2_vel_reg  <= s1_vel_reg;
        s2_curv_reg <= s1_curv_reg;
        s2_bnd_reg  <= s1_bnd_reg;

        s3_ctl_reg  <= s2_ctl_reg;
        s3_val_reg  <= s2_val_reg;
        s3_p1_reg   <= p1_next;
        s3_p2_reg   <= p2_next;
        s3_base_reg <= base_next;

        if (s3_vld_reg)
        begin
            fifo_mem_reg[wr_ptr_reg[FPTR_W-1:0]] <= '{
                point_index:   s3_ctl_reg.idx,
                new_value:     res_value,
                last_in_layer: s3_ctl_reg.last,
                saturated:     res_sat
            };
        end
    end

endmodule

`default_nettype wire

// ===== design/wels_ram.sv =====
// Generic single-write, single-read RAM with registered, write-first read.
// No package dependency.
`default_nettype none

module wels_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // same-edge write to the read address returns the new word
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
